>>> sv/tpmp_pkg.sv
// Shared constants and types for the two-wheel PD motion profile block.
package tpmp_pkg;

	localparam int DIV_W   = 38;
	localparam int DSOR_W  = 16;
	localparam int CNT_W   = 6;

	localparam logic [2:0] REG_MAX_STEP   = 3'd0;
	localparam logic [2:0] REG_MIN_STEP   = 3'd1;
	localparam logic [2:0] REG_ACCEL_TIME = 3'd2;
	localparam logic [2:0] REG_LEFT_KP    = 3'd3;
	localparam logic [2:0] REG_LEFT_KD    = 3'd4;
	localparam logic [2:0] REG_RIGHT_KP   = 3'd5;
	localparam logic [2:0] REG_RIGHT_KD   = 3'd6;
	localparam logic [2:0] REG_ROT_KP     = 3'd7;

	localparam logic [15:0] ROT_KD    = 16'd0;
	localparam int          FRAC_BITS = 8;
	localparam int          CNT_FRAC  = 8;

	// mm * 30000 * 256 / 1720, exact by reciprocal over the 14-bit length range
	localparam logic [35:0] MM_RECIP   = 36'd4682013768;
	localparam int          MM_SHIFT   = 20;
	// encoder magnitude * 256 / 1000, exact over the 17-bit magnitude range
	localparam logic [35:0] LEFT_RECIP = 36'd2147484;
	localparam int          LEFT_SHIFT = 23;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic [15:0] left_drive;
		logic [15:0] right_drive;
		logic        move_done;
		logic        decelerating;
	} res_t;

endpackage

>>> sv/tpmp_div.sv
// Restoring divider, one quotient bit per cycle.
module tpmp_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [tpmp_pkg::DIV_W-1:0]        dividend,
	input  logic [tpmp_pkg::DSOR_W-1:0]       divisor,
	output logic [tpmp_pkg::DIV_W-1:0]        quotient,
	output tpmp_pkg::div_stat_t               stat
);

	logic [tpmp_pkg::DIV_W-1:0]  quo_q;
	logic [tpmp_pkg::DSOR_W-1:0] rem_q;
	logic [tpmp_pkg::DSOR_W-1:0] dsor_q;
	logic [tpmp_pkg::CNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [tpmp_pkg::DSOR_W:0]   trial;
	logic                        fits;

	assign trial = {rem_q, quo_q[tpmp_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, dsor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == tpmp_pkg::CNT_W'(tpmp_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dsor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[tpmp_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? tpmp_pkg::DSOR_W'(trial - {1'b0, dsor_q})
				: trial[tpmp_pkg::DSOR_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> sv/two_wheel_pd_motion_profile.sv
// Top level: two-wheel PD position controller with a ramped motion profile.
// One item is taken at a time; in_ready is high only while the sequencer is idle.
// A start uses the shared multiplier to scale the length, then loads the move.
// A tick measures the wheels, decides whether to decelerate and, when
// decelerating, takes the ramp step through the divider; the PD sums then run
// through the shared multiplier. A tick after the move has ended goes straight
// to the output. A finished result waits in the output
// register while the next item is taken; the next result holds the sequencer
// until the waiting one is transferred.
module two_wheel_pd_motion_profile (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [13:0]        target_mm,
	input  logic               left_reverse,
	input  logic               right_reverse,
	input  logic signed [15:0] left_count,
	input  logic signed [15:0] right_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] left_drive,
	output logic signed [15:0] right_drive,
	output logic               move_done,
	output logic               decelerating
);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_SMUL = 12'b000000000010,
		ST_SLD  = 12'b000000000100,
		ST_TM3  = 12'b000000001000,
		ST_TM1  = 12'b000000010000,
		ST_TM2  = 12'b000000100000,
		ST_TDIV = 12'b000001000000,
		ST_TWD  = 12'b000010000000,
		ST_TERR = 12'b000100000000,
		ST_TPD  = 12'b001000000000,
		ST_TFIN = 12'b010000000000,
		ST_OUT  = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [11:0] max_step_q, min_step_q;
	logic [15:0] accel_q, lkp_q, lkd_q, rkp_q, rkd_q, rotkp_q;

	logic [31:0] target_q, left_tot_q, right_tot_q, set_tot_q;
	logic signed [32:0] lel_q, rel_q, rotel_q;
	logic [15:0] tick_q;
	logic lbk_q, rbk_q, fin_q;

	logic [13:0] mm_q;
	logic [16:0] lmag_q, rmag_q;
	logic decel_q, num_neg_q;
	logic signed [32:0] el_q, er_q, d_q;
	logic signed [33:0] del_q, der_q, dd_q;
	logic signed [56:0] lacc_q, racc_q, p_q;
	logic [2:0] mcnt_q;
	tpmp_pkg::res_t res_q;
	logic out_valid_q;

	logic signed [20:0] mul_a;
	logic signed [35:0] mul_b;
	logic [19:0] m_w;
	logic [17:0] ct_w;
	logic [15:0] tdiv_w;
	logic signed [37:0] num_w;
	logic [37:0] num_mag_w;
	logic div_start;
	logic [37:0] div_dend, div_quo;
	logic [15:0] div_dsor;
	tpmp_pkg::div_stat_t div_st;
	logic signed [32:0] el_w, er_w, d_w;
	logic signed [39:0] q_s_w, step_w, floor_w;
	logic [31:0] tgt_w;
	logic reached_w;
	logic slot_free;

	function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [39:0] b);
		logic [40:0] s;
		s = {9'b0, a} + {1'b0, b};
		return (s > 41'h0FFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
	endfunction

	function automatic logic [15:0] drive_out(input logic signed [56:0] s, input logic rev);
		logic [56:0] mag;
		logic [40:0] sh;
		logic signed [41:0] v;
		mag = s[56] ? 57'(-s) : 57'(s);
		sh  = mag[56:tpmp_pkg::CNT_FRAC + tpmp_pkg::FRAC_BITS];
		v   = s[56] ? -$signed({1'b0, sh}) : $signed({1'b0, sh});
		if (rev)
			v = -v;
		if (v > 42'sd32767)
			return 16'h7FFF;
		if (v < -42'sd32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	assign m_w       = {max_step_q, 8'b0};
	assign ct_w      = {1'b0, tick_q, 1'b0} + {2'b0, accel_q};
	assign tdiv_w    = (accel_q == 16'd0) ? 16'd1 : accel_q;
	assign num_w     = $signed(p_q[37:0] - {6'b0, target_q});
	assign num_mag_w = num_w[37] ? 38'(-num_w) : 38'(num_w);
	assign tgt_w     = p_q[tpmp_pkg::MM_SHIFT +: 32];
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		mul_a = $signed({1'b0, m_w});
		mul_b = $signed({20'b0, tick_q});
		unique case (state_q)
			ST_SMUL: begin
				mul_a = $signed({7'b0, mm_q});
				mul_b = $signed(tpmp_pkg::MM_RECIP);
			end
			ST_TM1: begin
				mul_a = $signed({4'b0, lmag_q});
				mul_b = $signed(tpmp_pkg::LEFT_RECIP);
			end
			ST_TM2: begin
				mul_b = $signed({18'b0, ct_w});
			end
			ST_TPD: begin
				unique case (mcnt_q)
					3'd0: begin
						mul_a = $signed({5'b0, lkp_q});
						mul_b = {{3{el_q[32]}}, el_q};
					end
					3'd1: begin
						mul_a = $signed({5'b0, lkd_q});
						mul_b = {{2{del_q[33]}}, del_q};
					end
					3'd2: begin
						mul_a = $signed({5'b0, rotkp_q});
						mul_b = {{3{d_q[32]}}, d_q};
					end
					3'd3: begin
						mul_a = $signed({5'b0, tpmp_pkg::ROT_KD});
						mul_b = {{2{dd_q[33]}}, dd_q};
					end
					3'd4: begin
						mul_a = $signed({5'b0, rkp_q});
						mul_b = {{3{er_q[32]}}, er_q};
					end
					3'd5: begin
						mul_a = $signed({5'b0, rkd_q});
						mul_b = {{2{der_q[33]}}, der_q};
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign div_dend  = num_mag_w;
	assign div_dsor  = tdiv_w;
	assign div_start = (state_q == ST_TDIV) && decel_q;

	tpmp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dend),
		.divisor  (div_dsor),
		.quotient (div_quo),
		.stat     (div_st)
	);

	assign q_s_w   = num_neg_q ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
	assign floor_w = $signed({20'b0, min_step_q, 8'b0});
	always_comb begin
		step_w = decel_q ? ($signed({20'b0, m_w}) - q_s_w) : $signed({20'b0, m_w});
		if (step_w <= floor_w)
			step_w = floor_w;
	end

	assign el_w = $signed({1'b0, set_tot_q}) - $signed({1'b0, left_tot_q});
	assign er_w = $signed({1'b0, set_tot_q}) - $signed({1'b0, right_tot_q});
	assign d_w  = $signed({1'b0, left_tot_q}) - $signed({1'b0, right_tot_q});
	assign reached_w = (left_tot_q >= target_q) || (right_tot_q >= target_q);

	always_ff @(posedge clk)
		p_q <= mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q <= 12'd100;
			min_step_q <= 12'd10;
			accel_q    <= 16'd50;
			lkp_q      <= 16'd256;
			lkd_q      <= 16'd0;
			rkp_q      <= 16'd256;
			rkd_q      <= 16'd0;
			rotkp_q    <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tpmp_pkg::REG_MAX_STEP:   max_step_q <= cfg_data[11:0];
				tpmp_pkg::REG_MIN_STEP:   min_step_q <= cfg_data[11:0];
				tpmp_pkg::REG_ACCEL_TIME: accel_q    <= cfg_data;
				tpmp_pkg::REG_LEFT_KP:    lkp_q      <= cfg_data;
				tpmp_pkg::REG_LEFT_KD:    lkd_q      <= cfg_data;
				tpmp_pkg::REG_RIGHT_KP:   rkp_q      <= cfg_data;
				tpmp_pkg::REG_RIGHT_KD:   rkd_q      <= cfg_data;
				tpmp_pkg::REG_ROT_KP:     rotkp_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			target_q    <= '0;
			left_tot_q  <= '0;
			right_tot_q <= '0;
			set_tot_q   <= '0;
			lel_q       <= '0;
			rel_q       <= '0;
			rotel_q     <= '0;
			tick_q      <= '0;
			lbk_q       <= 1'b0;
			rbk_q       <= 1'b0;
			fin_q       <= 1'b1;
			decel_q     <= 1'b0;
			num_neg_q   <= 1'b0;
			mcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (!op) begin
							lbk_q   <= left_reverse;
							rbk_q   <= right_reverse;
							state_q <= ST_SMUL;
						end else if (fin_q) begin
							state_q <= ST_OUT;
						end else begin
							if (tick_q != 16'hFFFF)
								tick_q <= tick_q + 16'd1;
							state_q <= ST_TM1;
						end
					end
				end
				ST_SMUL: state_q <= ST_SLD;
				ST_SLD: begin
					target_q    <= tgt_w;
					left_tot_q  <= '0;
					right_tot_q <= '0;
					set_tot_q   <= '0;
					lel_q       <= '0;
					rel_q       <= '0;
					rotel_q     <= '0;
					tick_q      <= '0;
					fin_q       <= (tgt_w == 32'd0);
					state_q     <= ST_OUT;
				end
				ST_TM1: state_q <= ST_TM2;
				ST_TM2: begin
					left_tot_q  <= add_sat(left_tot_q, {15'b0, lmag_q, 8'b0}
						+ {26'b0, p_q[tpmp_pkg::LEFT_SHIFT +: 14]});
					right_tot_q <= add_sat(right_tot_q, {15'b0, rmag_q, 8'b0});
					state_q     <= ST_TM3;
				end
				ST_TM3: begin
					decel_q <= $signed({24'b0, target_q, 1'b0}) <= p_q;
					state_q <= ST_TDIV;
				end
				ST_TDIV: begin
					num_neg_q <= num_w[37];
					state_q   <= ST_TWD;
				end
				ST_TWD: begin
					if (!decel_q || div_st.done) begin
						set_tot_q <= add_sat(set_tot_q, 40'(step_w));
						state_q   <= ST_TERR;
					end
				end
				ST_TERR: begin
					mcnt_q  <= '0;
					state_q <= ST_TPD;
				end
				ST_TPD: begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd6)
						state_q <= ST_TFIN;
				end
				ST_TFIN: begin
					lel_q   <= el_q;
					rel_q   <= er_q;
					rotel_q <= d_q;
					if (reached_w)
						fin_q <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mm_q   <= target_mm;
				lmag_q <= left_count[15] ? (17'd0 - {left_count[15], left_count})
					: {1'b0, left_count};
				rmag_q <= right_count[15] ? (17'd0 - {right_count[15], right_count})
					: {1'b0, right_count};
				res_q  <= '{left_drive: 16'd0, right_drive: 16'd0,
					move_done: 1'b1, decelerating: 1'b0};
			end
			ST_SLD: begin
				res_q.move_done <= (tgt_w == 32'd0);
			end
			ST_TERR: begin
				el_q   <= el_w;
				er_q   <= er_w;
				d_q    <= d_w;
				del_q  <= {el_w[32], el_w} - {lel_q[32], lel_q};
				der_q  <= {er_w[32], er_w} - {rel_q[32], rel_q};
				dd_q   <= {d_w[32], d_w} - {rotel_q[32], rotel_q};
				lacc_q <= '0;
				racc_q <= '0;
			end
			ST_TPD: begin
				unique case (mcnt_q)
					3'd1, 3'd2: lacc_q <= lacc_q + p_q;
					3'd3, 3'd4: begin
						lacc_q <= lacc_q - p_q;
						racc_q <= racc_q + p_q;
					end
					3'd5, 3'd6: racc_q <= racc_q + p_q;
					default: ;
				endcase
			end
			ST_TFIN: begin
				res_q.move_done    <= reached_w;
				res_q.decelerating <= decel_q;
				res_q.left_drive   <= reached_w ? 16'd0 : drive_out(lacc_q, lbk_q);
				res_q.right_drive  <= reached_w ? 16'd0 : drive_out(racc_q, rbk_q);
			end
			default: ;
		endcase
		if (state_q == ST_OUT && slot_free) begin
			left_drive   <= res_q.left_drive;
			right_drive  <= res_q.right_drive;
			move_done    <= res_q.move_done;
			decelerating <= res_q.decelerating;
		end
	end

	assign out_valid = out_valid_q;

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && move_done) |-> (left_drive == 16'd0 && right_drive == 16'd0))
		else $error("drive not zero on finished result");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_st.busy)
		else $error("divider busy while idle");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_OUT))
		else $error("result raised outside output state");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the two-wheel PD motion profile block.
`timescale 1ns / 1ps

class drive_scoreboard;
	logic [11:0] max_step, min_step;
	logic [15:0] accel_time, left_kp, left_kd, right_kp, right_kd, rot_kp;
	logic [31:0] target_q, left_total, right_total, set_total;
	longint left_last, right_last, rot_last;
	int unsigned ticks;
	bit left_bwd, right_bwd, finished;
	tpmp_pkg::res_t pending[$];
	int errors;

	function void clear();
		max_step = 100; min_step = 10; accel_time = 50;
		left_kp = 256; left_kd = 0; right_kp = 256; right_kd = 0; rot_kp = 0;
		target_q = 0; left_total = 0; right_total = 0; set_total = 0;
		left_last = 0; right_last = 0; rot_last = 0; ticks = 0;
		left_bwd = 0; right_bwd = 0; finished = 1;
		errors = 0;
		pending.delete();
	endfunction

	function void write_reg(logic [2:0] idx, logic [15:0] val);
		case (idx)
			tpmp_pkg::REG_MAX_STEP:   max_step = val[11:0];
			tpmp_pkg::REG_MIN_STEP:   min_step = val[11:0];
			tpmp_pkg::REG_ACCEL_TIME: accel_time = val;
			tpmp_pkg::REG_LEFT_KP:    left_kp = val;
			tpmp_pkg::REG_LEFT_KD:    left_kd = val;
			tpmp_pkg::REG_RIGHT_KP:   right_kp = val;
			tpmp_pkg::REG_RIGHT_KD:   right_kd = val;
			default:                  rot_kp = val;
		endcase
	endfunction

	function logic [31:0] add_sat(logic [31:0] a, longint b);
		longint s;
		s = longint'(a) + b;
		return (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
	endfunction

	function logic [15:0] drive_of(longint sum, bit rev);
		longint v;
		v = (sum < 0) ? -((-sum) >>> 16) : (sum >>> 16);
		if (rev) v = -v;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function void note_item(bit op, logic [13:0] mm, bit lr, bit rr,
			logic signed [15:0] lc, logic signed [15:0] rc);
		tpmp_pkg::res_t r;
		longint m_q, t_q, stp, num, q, tdiv, el, er, d, ls, rs, la, ra;
		bit dec;
		r = '0;
		if (!op) begin
			target_q = (longint'(mm) * 30000 * 256) / 1720;
			left_total = 0; right_total = 0; set_total = 0;
			left_last = 0; right_last = 0; rot_last = 0; ticks = 0;
			left_bwd = lr; right_bwd = rr;
			finished = (target_q == 0);
			r.move_done = finished;
		end else if (finished) begin
			r.move_done = 1;
		end else begin
			if (ticks < 65535) ticks++;
			m_q = longint'(max_step) * 256;
			t_q = target_q;
			dec = 2 * t_q <= m_q * (2 * longint'(ticks) + longint'(accel_time));
			la = lc < 0 ? -longint'(lc) : longint'(lc);
			ra = rc < 0 ? -longint'(rc) : longint'(rc);
			left_total = add_sat(left_total, (la * 256 * 1001) / 1000);
			right_total = add_sat(right_total, ra * 256);
			stp = m_q;
			if (dec) begin
				num = m_q * longint'(ticks) - t_q;
				tdiv = accel_time == 0 ? 1 : longint'(accel_time);
				q = (num >= 0) ? num / tdiv : -((-num) / tdiv);
				stp = m_q - q;
			end
			if (stp <= longint'(min_step) * 256) stp = longint'(min_step) * 256;
			set_total = add_sat(set_total, stp);
			el = longint'(set_total) - longint'(left_total);
			er = longint'(set_total) - longint'(right_total);
			d = longint'(left_total) - longint'(right_total);
			ls = longint'(left_kp) * el + longint'(left_kd) * (el - left_last)
				- longint'(rot_kp) * d - longint'(tpmp_pkg::ROT_KD) * (d - rot_last);
			rs = longint'(right_kp) * er + longint'(right_kd) * (er - right_last)
				+ longint'(rot_kp) * d + longint'(tpmp_pkg::ROT_KD) * (d - rot_last);
			left_last = el; right_last = er; rot_last = d;
			r.decelerating = dec;
			if (left_total >= target_q || right_total >= target_q) begin
				finished = 1;
				r.move_done = 1;
			end else begin
				r.left_drive = drive_of(ls, left_bwd);
				r.right_drive = drive_of(rs, right_bwd);
			end
		end
		pending.push_back(r);
	endfunction

	function void report_err(string msg);
		errors++;
		$display("mismatch: %s", msg);
	endfunction

	function void check_result(tpmp_pkg::res_t got);
		tpmp_pkg::res_t exp_r;
		if (pending.size() == 0) begin
			report_err("result with nothing pending");
			return;
		end
		exp_r = pending.pop_front();
		if (got.left_drive !== exp_r.left_drive)
			report_err($sformatf("left_drive %0d want %0d",
				$signed(got.left_drive), $signed(exp_r.left_drive)));
		if (got.right_drive !== exp_r.right_drive)
			report_err($sformatf("right_drive %0d want %0d",
				$signed(got.right_drive), $signed(exp_r.right_drive)));
		if (got.move_done !== exp_r.move_done)
			report_err($sformatf("move_done %b want %b", got.move_done, exp_r.move_done));
		if (got.decelerating !== exp_r.decelerating)
			report_err($sformatf("decelerating %b want %b",
				got.decelerating, exp_r.decelerating));
	endfunction
endclass

module tb_top;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid, in_ready, op, left_reverse, right_reverse;
	logic [13:0] target_mm;
	logic signed [15:0] left_count, right_count;
	logic out_valid, out_ready;
	logic signed [15:0] left_drive, right_drive;
	logic move_done, decelerating;

	drive_scoreboard sb;
	bit calm;
	longint cycles;

	two_wheel_pd_motion_profile dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		cfg_valid = 0; cfg_index = tpmp_pkg::REG_MAX_STEP; cfg_data = 0;
		in_valid = 0; op = 0; target_mm = 0; left_reverse = 0; right_reverse = 0;
		left_count = 0; right_count = 0; out_ready = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{left_drive, right_drive, move_done, decelerating});
		if (arst_n) out_ready <= calm || ($urandom_range(99) >= 26);
	end

	task automatic idle_gap();
		while (!calm && $urandom_range(99) < 26) begin
			in_valid <= 0;
			@(posedge clk);
		end
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	task automatic send_item(bit o, logic [13:0] mm, bit lr, bit rr,
			logic [15:0] lc, logic [15:0] rc);
		idle_gap();
		in_valid <= 1; op <= o; target_mm <= mm; left_reverse <= lr;
		right_reverse <= rr; left_count <= lc; right_count <= rc;
		do @(posedge clk); while (!in_ready);
		sb.note_item(o, mm, lr, rr, lc, rc);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic set_profile(logic [15:0] ms, logic [15:0] mn, logic [15:0] at,
			logic [15:0] lp, logic [15:0] ld, logic [15:0] rp, logic [15:0] rd,
			logic [15:0] rk);
		drain();
		cfg_write(tpmp_pkg::REG_MAX_STEP, ms);
		cfg_write(tpmp_pkg::REG_MIN_STEP, mn);
		cfg_write(tpmp_pkg::REG_ACCEL_TIME, at);
		cfg_write(tpmp_pkg::REG_LEFT_KP, lp);
		cfg_write(tpmp_pkg::REG_LEFT_KD, ld);
		cfg_write(tpmp_pkg::REG_RIGHT_KP, rp);
		cfg_write(tpmp_pkg::REG_RIGHT_KD, rd);
		cfg_write(tpmp_pkg::REG_ROT_KP, rk);
		cfg_valid <= 0;
	endtask

	function automatic logic [15:0] rand_count(int span);
		int v;
		v = $urandom_range(2 * span) - span;
		return v[15:0];
	endfunction

	task automatic random_move(int span, output int cnt);
		int n;
		send_item(1'b0, ($urandom_range(3) == 0) ? 14'($urandom) : 14'($urandom_range(300)),
			1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
		n = $urandom_range(40, 5);
		repeat (n) begin
			if ($urandom_range(19) == 0)
				send_item(1'($urandom), 14'($urandom), 1'($urandom), 1'($urandom),
					16'($urandom), 16'($urandom));
			else
				send_item(1'b1, 14'($urandom), 1'($urandom), 1'($urandom),
					rand_count(span), rand_count(span));
		end
		cnt = n + 1;
	endtask

	initial begin
		int sent, moves, cnt;
		sb = new();
		sb.clear();
		calm = 0;
		@(posedge arst_n);
		@(posedge clk);
		send_item(1, 0, 0, 0, 16'sd5, 16'sd5);
		send_item(0, 0, 1, 1, 0, 0);
		send_item(0, 14'd100, 0, 0, 0, 0);
		send_item(1, 0, 0, 0, 16'sh7FFF, 16'sh8000);
		send_item(0, 14'h3FFF, 1, 0, 0, 0);
		send_item(1, 0, 0, 0, 16'sd0, 16'sd0);
		send_item(1, 0, 0, 0, 16'sh8000, 16'sd1);
		send_item(1, 0, 0, 0, 16'sd30, -16'sd30);
		send_item(0, 14'd5, 0, 1, 0, 0);
		send_item(1, 0, 0, 0, 16'sd3, 16'sd2);
		send_item(1, 0, 0, 0, 16'sd20000, 16'sd1);
		send_item(1, 0, 0, 0, 16'sd1, 16'sd1);
		set_profile(16'd4095, 16'd4095, 16'd65535, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF);
		send_item(0, 14'h3FFF, 0, 1, 0, 0);
		send_item(1, 0, 0, 0, 16'sd1, -16'sd1);
		send_item(1, 0, 0, 0, -16'sd1, 16'sd0);
		set_profile(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_item(0, 14'd50, 1, 1, 0, 0);
		send_item(1, 0, 0, 0, 16'sd10, 16'sd10);
		set_profile(16'd1, 16'd0, 16'd1, 16'd256, 16'd128, 16'd512, 16'd64, 16'd300);
		send_item(0, 14'd2, 0, 0, 0, 0);
		repeat (4) send_item(1, 0, 0, 0, 16'sd1, 16'sd0);
		sent = 22;
		moves = 0;
		while (sent < 1850) begin
			calm = (moves % 12 == 1);
			if ($urandom_range(5) == 0) begin
				calm = 0;
				set_profile(16'($urandom_range(200)), 16'($urandom_range(30)),
					16'($urandom_range(3) == 0 ? $urandom : $urandom_range(60)),
					16'($urandom), 16'($urandom_range(2000)), 16'($urandom),
					16'($urandom_range(2000)),
					16'($urandom_range(3) == 0 ? $urandom : $urandom_range(500)));
			end
			random_move($urandom_range(1) ? 3000 : 32768, cnt);
			sent = sent + cnt;
			moves++;
		end
		calm = 0;
		drain();
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
